FILE: rtl/prq_pkg.sv
// Shared constants, codes and control types of the priority ready queue.
package prq_pkg;

	localparam int NUM_LEVELS = 32;
	localparam int MAX_TASKS  = 64;
	localparam int LEVEL_W    = $clog2(NUM_LEVELS);
	localparam int TASK_W     = $clog2(MAX_TASKS);
	localparam int OP_W       = 2;

	// Request operation codes. The fourth code is a no-op.
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_MOVE   = 2'd2
	} prq_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_APPEND,
		ST_FIND,
		ST_RESULT
	} prq_state_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic idle;
		logic exec;
		logic remove;
		logic append;
		logic find;
		logic load_out;
	} prq_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            busy;
		logic            req_valid;
		logic            out_free;
	} prq_sts_t;

endpackage

FILE: rtl/prq_if.sv
// Request and result channel interfaces of the priority ready queue.
interface prq_req_if;
	import prq_pkg::*;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [TASK_W-1:0]  task_id;
	logic [LEVEL_W-1:0] priority_req;

	modport source (output valid, op, task_id, priority_req, input ready);
	modport sink   (input valid, op, task_id, priority_req, output ready);
endinterface

interface prq_rsp_if;
	import prq_pkg::*;
	logic               valid;
	logic               ready;
	logic               high_valid;
	logic [TASK_W-1:0]  high_task;
	logic [LEVEL_W-1:0] high_priority;

	modport source (output valid, high_valid, high_task, high_priority, input ready);
	modport sink   (input valid, high_valid, high_task, high_priority, output ready);
endinterface

FILE: rtl/prq_ctrl.sv
// Sequencer of the priority ready queue: steps one request through its phases.
module prq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  prq_pkg::prq_sts_t  sts,
	output prq_pkg::prq_cmd_t  cmd
);
	import prq_pkg::*;

	prq_state_t state_q;
	prq_state_t state_d;
	logic       unlinks;

	// Remove and move unlink the task first, and only from a nonempty level.
	assign unlinks = ((sts.op == OP_REMOVE) || (sts.op == OP_MOVE)) && sts.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (sts.op)
					OP_APPEND: state_d = ST_APPEND;
					OP_MOVE:   state_d = sts.busy ? ST_APPEND : ST_FIND;
					default:   state_d = ST_FIND;
				endcase
			end
			ST_APPEND: state_d = ST_FIND;
			ST_FIND:   state_d = ST_RESULT;
			ST_RESULT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.idle = 1'b1;
			ST_EXEC: begin
				cmd.exec   = 1'b1;
				cmd.remove = unlinks;
			end
			ST_APPEND: cmd.append = 1'b1;
			ST_FIND:   cmd.find = 1'b1;
			ST_RESULT: cmd.load_out = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

FILE: rtl/prq_dp.sv
// Datapath of the priority ready queue: link tables, ready bitmap and result register.
module prq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  prq_pkg::prq_cmd_t cmd,
	output prq_pkg::prq_sts_t sts,
	prq_req_if.sink           req,
	prq_rsp_if.source         rsp
);
	import prq_pkg::*;

	// Accepted request.
	logic [OP_W-1:0]    op_q;
	logic [TASK_W-1:0]  task_q;
	logic [LEVEL_W-1:0] prio_q;

	logic [NUM_LEVELS-1:0] bitmap_q;

	// Per-level head and tail, per-task links.
	logic [TASK_W-1:0] head_mem [NUM_LEVELS];
	logic [TASK_W-1:0] tail_mem [NUM_LEVELS];
	logic [TASK_W-1:0] next_mem [MAX_TASKS];
	logic [TASK_W-1:0] prev_mem [MAX_TASKS];

	logic [TASK_W-1:0] head_rd_q;
	logic [TASK_W-1:0] tail_rd_q;
	logic [TASK_W-1:0] next_rd_q;
	logic [TASK_W-1:0] prev_rd_q;

	// Level state after the unlink step, used by the append step.
	logic [TASK_W-1:0] cur_head_q;
	logic [TASK_W-1:0] cur_tail_q;
	logic              cur_busy_q;

	logic [LEVEL_W-1:0] top_lvl_q;
	logic               top_any_q;

	logic               out_valid_q;
	logic               out_high_valid_q;
	logic [TASK_W-1:0]  out_task_q;
	logic [LEVEL_W-1:0] out_prio_q;

	logic               accept;
	logic               busy;
	logic               is_head;
	logic               is_tail;
	logic               only_one;
	logic [TASK_W-1:0]  new_head;
	logic [TASK_W-1:0]  new_tail;
	logic [LEVEL_W-1:0] lvl_raddr;
	logic [LEVEL_W-1:0] ffs_lvl;

	logic               lvl_we;
	logic [TASK_W-1:0]  lvl_whead;
	logic [TASK_W-1:0]  lvl_wtail;
	logic               next_we;
	logic [TASK_W-1:0]  next_waddr;
	logic [TASK_W-1:0]  next_wdata;
	logic               prev_we;
	logic [TASK_W-1:0]  prev_waddr;
	logic [TASK_W-1:0]  prev_wdata;

	assign accept    = req.valid && cmd.idle;
	assign req.ready = cmd.idle;

	assign busy     = bitmap_q[prio_q];
	assign is_head  = (head_rd_q == task_q);
	assign is_tail  = (tail_rd_q == task_q);
	assign only_one = is_head && is_tail;
	assign new_head = (cmd.remove && is_head) ? next_rd_q : head_rd_q;
	assign new_tail = (cmd.remove && is_tail) ? prev_rd_q : tail_rd_q;

	assign sts.op        = op_q;
	assign sts.busy      = busy;
	assign sts.req_valid = req.valid;
	assign sts.out_free  = !out_valid_q || rsp.ready;

	// Lowest-numbered set bit of the ready bitmap.
	always_comb begin
		ffs_lvl = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (bitmap_q[i]) begin
				ffs_lvl = LEVEL_W'(i);
			end
		end
	end

	// Outside idle the level port follows the lowest busy level, so the head read at the
	// find step stays put while a finished result waits for the result register.
	always_comb begin
		if (cmd.idle) begin
			lvl_raddr = req.priority_req;
		end else begin
			lvl_raddr = ffs_lvl;
		end
	end

	always_comb begin
		lvl_we     = 1'b0;
		lvl_whead  = new_head;
		lvl_wtail  = new_tail;
		next_we    = 1'b0;
		next_waddr = prev_rd_q;
		next_wdata = is_tail ? task_q : next_rd_q;
		prev_we    = 1'b0;
		prev_waddr = next_rd_q;
		prev_wdata = prev_rd_q;
		if (cmd.exec && cmd.remove && !only_one) begin
			lvl_we  = 1'b1;
			next_we = !is_head;
			prev_we = !is_head && !is_tail;
		end else if (cmd.append) begin
			lvl_we    = 1'b1;
			lvl_wtail = task_q;
			if (cur_busy_q) begin
				lvl_whead  = cur_head_q;
				next_we    = 1'b1;
				next_waddr = cur_tail_q;
				next_wdata = task_q;
				prev_we    = 1'b1;
				prev_waddr = task_q;
				prev_wdata = cur_tail_q;
			end else begin
				lvl_whead = task_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lvl_we) begin
			head_mem[prio_q] <= lvl_whead;
			tail_mem[prio_q] <= lvl_wtail;
		end
		head_rd_q <= head_mem[lvl_raddr];
		tail_rd_q <= tail_mem[lvl_raddr];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		next_rd_q <= next_mem[req.task_id];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
		prev_rd_q <= prev_mem[req.task_id];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			task_q <= req.task_id;
			prio_q <= req.priority_req;
		end
		if (cmd.exec) begin
			cur_head_q <= new_head;
			cur_tail_q <= new_tail;
		end
		if (cmd.find) begin
			top_lvl_q <= ffs_lvl;
		end
		if (cmd.load_out) begin
			out_high_valid_q <= top_any_q;
			out_task_q       <= top_any_q ? head_rd_q : '0;
			out_prio_q       <= top_any_q ? top_lvl_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q    <= '0;
			cur_busy_q  <= 1'b0;
			top_any_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				cur_busy_q <= busy && !(cmd.remove && only_one);
				if (cmd.remove && only_one) begin
					bitmap_q[prio_q] <= 1'b0;
				end
			end
			if (cmd.append && !cur_busy_q) begin
				bitmap_q[prio_q] <= 1'b1;
			end
			if (cmd.find) begin
				top_any_q <= |bitmap_q;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.high_valid    = out_high_valid_q;
	assign rsp.high_task     = out_task_q;
	assign rsp.high_priority = out_prio_q;

endmodule

FILE: rtl/priority_ready_queue.sv
// Top level of the priority ready queue: sequencer and datapath.
//
// The block keeps one FIFO of task ids for each of 32 priority levels,
// linked through per-task next and previous tables, plus a ready bitmap.
// Requests arrive on the req channel (op, task_id, priority_req): append
// the task to its level, remove it, or move it to the tail of its level.
// For every request beat exactly one result beat leaves on the rsp
// channel: the head task of the lowest-numbered nonempty level, that
// level, and high_valid; with every level empty all three fields are 0.
// A request runs through the exec, find and result steps; append, and a
// move on a nonempty level, add an append step between exec and find,
// since each table has a single write port and the unlink writes of a
// move take the exec step.
// The next request is accepted the cycle after the result is loaded, so
// a new request is never taken while the sequencer works on an earlier one.
// The result register frees the input side: a new request is accepted
// and processed while an earlier result still waits on rsp. If the
// receiver stalls, a second result holds in the sequencer until the
// register drains. Reset (arst_n, asynchronous) empties the bitmap and
// the result register; the link tables need no clearing.
module priority_ready_queue (
	input logic       clk,
	input logic       arst_n,
	prq_req_if.sink   req,
	prq_rsp_if.source rsp
);
	import prq_pkg::*;

	prq_cmd_t cmd;
	prq_sts_t sts;

	// Sequencer: decides which phase runs each cycle.
	prq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath: tables, bitmap, find-first-set and the result register.
	prq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

FILE: rtl/prq_checker.sv
// Port-level checker of the priority ready queue and its bind.
module prq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        high_valid,
	input logic [prq_pkg::TASK_W-1:0]  high_task,
	input logic [prq_pkg::LEVEL_W-1:0] high_priority
);
	import prq_pkg::*;

	logic [2:0] pending_q;
	logic       req_beat;
	logic       rsp_beat;

	assign req_beat = req_valid && req_ready;
	assign rsp_beat = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(req_beat) - 3'(rsp_beat);
		end
	end

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more than two requests outstanding");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 3'd0) |-> !rsp_valid)
		else $error("result beat without a request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |=> !req_ready)
		else $error("request accepted while the previous one is in work");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !high_valid) |-> (high_task == '0 && high_priority == '0))
		else $error("empty queue result carries nonzero fields");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result beat dropped while stalled");

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.high_valid    (rsp.high_valid),
	.high_task     (rsp.high_task),
	.high_priority (rsp.high_priority)
);

FILE: tb/sv/tb_priority_ready_queue.sv
// Self-checking testbench of the priority ready queue: randomized request traffic and result checks.
module tb_priority_ready_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import prq_pkg::*;

	// The fourth operation code has no name in the package; the block treats it as a no-op.
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;

	localparam int MAIN_ITEMS   = 1380;
	localparam int CHAOS_ITEMS  = 150;
	localparam int STALL_LIMIT  = 500;
	localparam int DRAIN_CYCLES = 30;
	localparam int PRINT_LIMIT  = 40;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [TASK_W-1:0]  task_id;
		logic [LEVEL_W-1:0] priority_req;
	} sched_req_t;

	typedef struct packed {
		logic               high_valid;
		logic [TASK_W-1:0]  high_task;
		logic [LEVEL_W-1:0] high_priority;
	} top_report_t;

	// A planned request beat together with the top-of-queue report it must produce.
	typedef struct packed {
		sched_req_t  req;
		top_report_t top;
	} sched_beat_t;

	logic clk;
	logic arst_n;

	prq_req_if req();
	prq_rsp_if rsp();

	priority_ready_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow of the scheduler state. The *_known flags record which link entries have
	// been written, so that the stimulus never makes the block read an unwritten one.
	logic [NUM_LEVELS-1:0] ready_levels;
	logic [TASK_W-1:0]     lvl_first [NUM_LEVELS];
	logic [TASK_W-1:0]     lvl_last  [NUM_LEVELS];
	logic [TASK_W-1:0]     succ      [MAX_TASKS];
	logic [TASK_W-1:0]     pred      [MAX_TASKS];
	bit                    succ_known[MAX_TASKS];
	bit                    pred_known[MAX_TASKS];

	sched_beat_t requests_planned[$];
	top_report_t tops_owed[$];
	sched_beat_t in_flight;

	// Which level each task sits at while the traffic is still well formed; -1 when unqueued.
	int queued_tasks[$];
	int home_level[MAX_TASKS];

	int op_planned[4];
	int total_requests;
	int requests_sent;
	int results_seen;
	int empty_reports;
	int mismatches;
	int idle_cycles;

	bit req_taken;
	bit rsp_taken;
	int send_wait;
	int send_calm;
	int rsp_stall;
	int rsp_calm;

	// Appends a task at the tail of its level.
	function automatic void link_tail(logic [TASK_W-1:0] t, logic [LEVEL_W-1:0] p);
		if (!ready_levels[p]) begin
			lvl_first[p]    = t;
			lvl_last[p]     = t;
			ready_levels[p] = 1'b1;
		end else begin
			succ[lvl_last[p]]       = t;
			succ_known[lvl_last[p]] = 1'b1;
			pred[t]                 = lvl_last[p];
			pred_known[t]           = 1'b1;
			lvl_last[p]             = t;
		end
	endfunction

	// Unlinks a task from a level, trusting its links even when it is not really there.
	function automatic void unlink_task(logic [TASK_W-1:0] t, logic [LEVEL_W-1:0] p);
		logic at_head;
		logic at_tail;
		if (!ready_levels[p])
			return;
		at_head = (lvl_first[p] == t);
		at_tail = (lvl_last[p] == t);
		if (at_head && at_tail) begin
			ready_levels[p] = 1'b0;
			return;
		end
		if (at_head) begin
			lvl_first[p] = succ[t];
		end else begin
			succ_known[pred[t]] = 1'b1;
			succ[pred[t]]       = at_tail ? t : succ[t];
		end
		if (at_tail) begin
			lvl_last[p] = pred[t];
		end else if (!at_head) begin
			pred_known[succ[t]] = 1'b1;
			pred[succ[t]]       = pred[t];
		end
	endfunction

	// True when unlinking the task reads only link entries that were written before.
	function automatic bit links_defined(logic [TASK_W-1:0] t, logic [LEVEL_W-1:0] p);
		logic at_head;
		logic at_tail;
		if (!ready_levels[p])
			return 1'b1;
		at_head = (lvl_first[p] == t);
		at_tail = (lvl_last[p] == t);
		if (at_head && at_tail)
			return 1'b1;
		if (at_head && !succ_known[t])
			return 1'b0;
		if (!at_head && !pred_known[t])
			return 1'b0;
		if (!at_head && !at_tail && !succ_known[t])
			return 1'b0;
		return 1'b1;
	endfunction

	// Applies one request to the shadow state and returns the resulting top report.
	function automatic top_report_t apply_request(sched_req_t r);
		top_report_t top;
		case (r.op)
			OP_APPEND: link_tail(r.task_id, r.priority_req);
			OP_REMOVE: unlink_task(r.task_id, r.priority_req);
			OP_MOVE: begin
				if (ready_levels[r.priority_req]) begin
					unlink_task(r.task_id, r.priority_req);
					link_tail(r.task_id, r.priority_req);
				end
			end
			default: ;
		endcase
		top = '0;
		// Scan downward so that the lowest busy level is the one that stays.
		for (int p = NUM_LEVELS - 1; p >= 0; p--) begin
			if (ready_levels[p]) begin
				top.high_valid    = 1'b1;
				top.high_task     = lvl_first[p];
				top.high_priority = LEVEL_W'(p);
			end
		end
		return top;
	endfunction

	// Queues a request beat with its expected report; refuses one that would read a
	// link entry never written.
	function automatic bit plan_request(logic [OP_W-1:0] op, int t, int p);
		sched_req_t  r;
		sched_beat_t b;
		r.op           = op;
		r.task_id      = TASK_W'(t);
		r.priority_req = LEVEL_W'(p);
		if ((op == OP_REMOVE || op == OP_MOVE) && !links_defined(r.task_id, r.priority_req))
			return 1'b0;
		b.req = r;
		b.top = apply_request(r);
		requests_planned.push_back(b);
		op_planned[op]++;
		return 1'b1;
	endfunction

	// Level choice for appends: mostly a few high levels so lists grow deep, with the
	// extreme levels drawn often.
	function automatic int pick_level();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return $urandom_range(0, 3);
		if (roll < 8)
			return $urandom_range(0, NUM_LEVELS - 1);
		if (roll == 8)
			return 0;
		return NUM_LEVELS - 1;
	endfunction

	// Idle cycles before the next beat, with occasional stretches of no idling at all.
	function automatic int next_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 9);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $realtime, results_seen,
				what, got, want);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Request driver. A new beat is offered at the falling edge once the previous one has
	// been taken and its trailing gap has run out; valid holds steady while ready is low.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req.valid || req_taken) begin
				if (requests_planned.size() != 0 && send_wait == 0) begin
					in_flight        = requests_planned.pop_front();
					req.op           <= in_flight.req.op;
					req.task_id      <= in_flight.req.task_id;
					req.priority_req <= in_flight.req.priority_req;
					req.valid        <= 1'b1;
					send_wait        = next_gap(send_calm);
				end else begin
					req.valid <= 1'b0;
					if (send_wait != 0)
						send_wait--;
				end
			end
		end
	end

	// Result receiver. After every result beat it draws a random stall and holds ready low
	// while it runs. The stall runs whether or not a result is waiting, so it lands on
	// every phase of the block's work.
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_taken)
				rsp_stall = next_gap(rsp_calm);
			if (rsp_stall > 0) begin
				rsp.ready <= 1'b0;
				rsp_stall--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Monitor. At each rising edge it records which channels moved a beat. An accepted
	// request commits its expected report; a result beat is checked against the oldest one.
	always @(posedge clk) begin
		top_report_t want;
		if (arst_n) begin
			req_taken = req.valid && req.ready;
			rsp_taken = rsp.valid && rsp.ready;
			if (req_taken) begin
				tops_owed.push_back(in_flight.top);
				requests_sent++;
			end
			if (rsp_taken) begin
				if (tops_owed.size() == 0) begin
					report_mismatch("result beat with nothing outstanding, high_task",
						8'(rsp.high_task), 8'h0);
				end else begin
					want = tops_owed.pop_front();
					if (rsp.high_valid !== want.high_valid)
						report_mismatch("high_valid", 8'(rsp.high_valid), 8'(want.high_valid));
					if (rsp.high_task !== want.high_task)
						report_mismatch("high_task", 8'(rsp.high_task), 8'(want.high_task));
					if (rsp.high_priority !== want.high_priority)
						report_mismatch("high_priority", 8'(rsp.high_priority),
							8'(want.high_priority));
					if (!want.high_valid)
						empty_reports++;
				end
				results_seen++;
			end
			idle_cycles = (req_taken || rsp_taken) ? 0 : idle_cycles + 1;
		end
	end

	initial begin
		int  regime;
		int  kind;
		int  t;
		int  p;
		int  idx;
		int  app_pct;
		int  rem_pct;
		int  chaos;
		bit  timed_out;

		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.op           = OP_APPEND;
		req.task_id      = '0;
		req.priority_req = '0;
		rsp.ready        = 1'b0;
		ready_levels     = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			succ_known[i] = 1'b0;
			pred_known[i] = 1'b0;
			home_level[i] = -1;
		end

		// Directed opening. The empty queue, remove and move on an empty level, the
		// no-op code with all-ones fields, the extreme tasks and levels, a duplicate
		// append of a lone task, moves of head and tail, and a remove naming a level the
		// task is not in (it is unlinked from its real level through its own links).
		void'(plan_request(OP_NOP, 0, 0));
		void'(plan_request(OP_REMOVE, 5, 3));
		void'(plan_request(OP_MOVE, 5, 3));
		void'(plan_request(OP_APPEND, 0, NUM_LEVELS - 1));
		void'(plan_request(OP_APPEND, 0, NUM_LEVELS - 1));
		void'(plan_request(OP_APPEND, MAX_TASKS - 1, 0));
		void'(plan_request(OP_APPEND, 10, 0));
		void'(plan_request(OP_MOVE, MAX_TASKS - 1, 0));
		void'(plan_request(OP_MOVE, MAX_TASKS - 1, 0));
		void'(plan_request(OP_NOP, MAX_TASKS - 1, NUM_LEVELS - 1));
		void'(plan_request(OP_REMOVE, 10, 0));
		void'(plan_request(OP_REMOVE, MAX_TASKS - 1, 0));
		void'(plan_request(OP_APPEND, 1, 5));
		void'(plan_request(OP_APPEND, 2, 5));
		void'(plan_request(OP_APPEND, 20, 7));
		void'(plan_request(OP_APPEND, 21, 7));
		void'(plan_request(OP_APPEND, 22, 7));
		void'(plan_request(OP_REMOVE, 21, 5));
		void'(plan_request(OP_MOVE, 20, 7));
		void'(plan_request(OP_REMOVE, 2, 5));
		void'(plan_request(OP_MOVE, 1, 5));
		void'(plan_request(OP_REMOVE, 0, NUM_LEVELS - 1));

		// What is left queued after the opening: task 1 at level 5, tasks 22 and 20 at 7.
		queued_tasks = '{1, 22, 20};
		home_level[1]  = 5;
		home_level[22] = 7;
		home_level[20] = 7;

		// Well-formed traffic in regimes that fill, drain or balance the queue, so that it
		// swings between empty and deep. About one request in ten is harmless noise.
		regime = 0;
		for (int n = 0; n < MAIN_ITEMS; n++) begin
			if (n % 100 == 0)
				regime = $urandom_range(0, 2);
			app_pct = (regime == 0) ? 60 : (regime == 1) ? 20 : 35;
			rem_pct = (regime == 0) ? 20 : (regime == 1) ? 60 : 30;
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1) == 0 || ready_levels == '1) begin
					void'(plan_request(OP_NOP, $urandom_range(0, MAX_TASKS - 1),
						$urandom_range(0, NUM_LEVELS - 1)));
				end else begin
					do
						p = $urandom_range(0, NUM_LEVELS - 1);
					while (ready_levels[p]);
					void'(plan_request($urandom_range(0, 1) ? OP_REMOVE : OP_MOVE,
						$urandom_range(0, MAX_TASKS - 1), p));
				end
			end else begin
				kind = $urandom_range(0, 99);
				if (queued_tasks.size() == 0 ||
						(queued_tasks.size() < MAX_TASKS && kind < app_pct)) begin
					do
						t = $urandom_range(0, MAX_TASKS - 1);
					while (home_level[t] >= 0);
					p = pick_level();
					void'(plan_request(OP_APPEND, t, p));
					home_level[t] = p;
					queued_tasks.push_back(t);
				end else if (kind < app_pct + rem_pct) begin
					idx = $urandom_range(0, queued_tasks.size() - 1);
					t   = queued_tasks[idx];
					void'(plan_request(OP_REMOVE, t, home_level[t]));
					home_level[t] = -1;
					queued_tasks.delete(idx);
				end else begin
					idx = $urandom_range(0, queued_tasks.size() - 1);
					t   = queued_tasks[idx];
					void'(plan_request(OP_MOVE, t, home_level[t]));
				end
			end
		end

		// Closing stretch of unrestricted requests: duplicate appends, removes and moves
		// at the wrong level, and corrupted lists. It comes last because it spoils the
		// lists for any well-formed traffic after it.
		chaos = 0;
		while (chaos < CHAOS_ITEMS) begin
			if (plan_request(OP_W'($urandom_range(0, 3)), $urandom_range(0, MAX_TASKS - 1),
					$urandom_range(0, NUM_LEVELS - 1)))
				chaos++;
		end
		total_requests = requests_planned.size();

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Run until every request has gone in and every report has come back, or until
		// the watchdog sees no beat move on either channel for too long.
		while ((requests_sent < total_requests || tops_owed.size() != 0) &&
				idle_cycles < STALL_LIMIT)
			@(negedge clk);
		timed_out = (idle_cycles >= STALL_LIMIT);
		if (!timed_out)
			repeat (DRAIN_CYCLES) @(negedge clk);
		if (timed_out)
			$display("Watchdog: no beat moved for %0d cycles", idle_cycles);
		if (tops_owed.size() != 0)
			report_mismatch("reports still outstanding at the end, count",
				8'(tops_owed.size()), 8'h0);

		$display("Sent %0d requests: %0d append, %0d remove, %0d move, %0d no-op.",
			requests_sent, op_planned[OP_APPEND], op_planned[OP_REMOVE],
			op_planned[OP_MOVE], op_planned[OP_NOP]);
		$display("Checked %0d result beats, %0d of them with no task ready.",
			results_seen, empty_reports);
		if (mismatches == 0 && !timed_out) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
